// ===== rtl/rgb_led_pattern_animator_assert.svh =====
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef RGB_LED_PATTERN_ANIMATOR_ASSERT_SVH
`define RGB_LED_PATTERN_ANIMATOR_ASSERT_SVH

// same-cycle implication
`define RLPA_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLPA_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgb_anim_pkg.sv =====
package rgb_anim_pkg;

  // request kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // pattern codes
  localparam logic [2:0] PAT_SOLID      = 3'd0;
  localparam logic [2:0] PAT_BLINK      = 3'd1;
  localparam logic [2:0] PAT_BLINK_FAST = 3'd2;
  localparam logic [2:0] PAT_FADE       = 3'd3;
  localparam logic [2:0] PAT_PULSE      = 3'd4;

  // speed codes
  localparam logic [1:0] SPEED_SLOW   = 2'd0;
  localparam logic [1:0] SPEED_NORMAL = 2'd1;
  localparam logic [1:0] SPEED_FAST   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_PER_SLOW   = 3'd1;
  localparam logic [2:0] REG_PER_NORMAL = 3'd2;
  localparam logic [2:0] REG_PER_FAST   = 3'd3;
  localparam logic [2:0] REG_PULSE_MIN  = 3'd4;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd5;
  localparam logic [2:0] REG_INTERVAL   = 3'd6;

  localparam logic [7:0]  RST_BRIGHTNESS = 8'd255;
  localparam logic [15:0] RST_PER_SLOW   = 16'd2000;
  localparam logic [15:0] RST_PER_NORMAL = 16'd1000;
  localparam logic [15:0] RST_PER_FAST   = 16'd500;
  localparam logic [6:0]  RST_PULSE_MIN  = 7'd10;
  localparam logic [6:0]  RST_PULSE_MAX  = 7'd100;
  localparam logic [15:0] RST_INTERVAL   = 16'd20;

  localparam logic [7:0]  LEVEL_FULL = 8'd255;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  // ceil(2^22 / 100), exact for values below 25600
  localparam logic [15:0] RECIP_100  = 16'd41944;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [15:0] per_slow;
    logic [15:0] per_normal;
    logic [15:0] per_fast;
    logic [6:0]  pulse_min;
    logic [6:0]  pulse_max;
    logic [15:0] update_interval;
  } cfg_regs_t;

  // pct * 255 / 100 with pct saturated at 100
  function automatic logic [7:0] pct_to_level(input logic [6:0] pct);
    logic [6:0]  sat;
    logic [14:0] scaled;
    logic [30:0] prod;
    sat    = (pct > PCT_FULL) ? PCT_FULL : pct;
    scaled = {sat, 8'd0} - 15'(sat);
    prod   = 31'(scaled) * 31'(RECIP_100);
    return prod[29:22];
  endfunction

  // x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // x / 65535 for quotients up to 255
  function automatic logic [7:0] div65535(input logic [23:0] x);
    logic [24:0] s;
    s = 25'(x) + 25'(x[23:16]) + 25'd1;
    return s[23:16];
  endfunction

endpackage

// ===== rtl/rgb_anim_regs.sv =====
module rgb_anim_regs
  import rgb_anim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   cfg
);

  cfg_regs_t   cfg_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness      <= RST_BRIGHTNESS;
      cfg_r.per_slow        <= RST_PER_SLOW;
      cfg_r.per_normal      <= RST_PER_NORMAL;
      cfg_r.per_fast        <= RST_PER_FAST;
      cfg_r.pulse_min       <= RST_PULSE_MIN;
      cfg_r.pulse_max       <= RST_PULSE_MAX;
      cfg_r.update_interval <= RST_INTERVAL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BRIGHTNESS: cfg_r.brightness      <= pwdata[7:0];
        REG_PER_SLOW:   cfg_r.per_slow        <= pwdata[15:0];
        REG_PER_NORMAL: cfg_r.per_normal      <= pwdata[15:0];
        REG_PER_FAST:   cfg_r.per_fast        <= pwdata[15:0];
        REG_PULSE_MIN:  cfg_r.pulse_min       <= pwdata[6:0];
        REG_PULSE_MAX:  cfg_r.pulse_max       <= pwdata[6:0];
        REG_INTERVAL:   cfg_r.update_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BRIGHTNESS: prdata = 32'(cfg_r.brightness);
      REG_PER_SLOW:   prdata = 32'(cfg_r.per_slow);
      REG_PER_NORMAL: prdata = 32'(cfg_r.per_normal);
      REG_PER_FAST:   prdata = 32'(cfg_r.per_fast);
      REG_PULSE_MIN:  prdata = 32'(cfg_r.pulse_min);
      REG_PULSE_MAX:  prdata = 32'(cfg_r.pulse_max);
      REG_INTERVAL:   prdata = 32'(cfg_r.update_interval);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/rgb_anim_div.sv =====
module rgb_anim_div
  import rgb_anim_pkg::*;
#(
  parameter int QB = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [16+QB-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [QB-1:0]    quotient
);

  localparam int DW = 16 + QB;
  localparam int CW = $clog2(QB + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   rem_r;
  logic [15:0]   dsr_r;
  logic [QB-1:0] dvd_r;
  logic [QB-1:0] quo_r;
  logic [16:0]   trial;
  logic [16:0]   diff;
  logic          ge;

  // quotient is known to fit QB bits, so the top of the dividend is the first remainder
  assign trial    = {rem_r, dvd_r[QB-1]};
  assign diff     = trial - {1'b0, dsr_r};
  assign ge       = trial >= {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QB);
        rem_r  <= dividend[DW-1:QB];
        dvd_r  <= dividend[QB-1:0];
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[15:0] : trial[15:0];
        dvd_r <= dvd_r << 1;
        quo_r <= {quo_r[QB-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rgb_anim_sine.sv =====
module rgb_anim_sine
  import rgb_anim_pkg::*;
#(
  parameter int SINE_ENTRIES = 256,
  parameter int SB = 8
) (
  input  logic          clk,
  input  logic [SB-1:0] rd_idx,
  output logic [15:0]   rd_data
);

  localparam logic [63:0] N64 = 64'(SINE_ENTRIES);

  logic [15:0] tbl [SINE_ENTRIES];
  logic [15:0] rd_data_r;

  function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x);
    return (((term * x) >> 30) * x) >> 30;
  endfunction

  // round(65535 * (1 + sin(2*pi*i/N)) / 2), quarter wave series in Q30
  function automatic logic [15:0] sine_entry(input int unsigned i);
    logic [63:0] u;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    u = 64'(i) << 2;
    q = u / N64;
    r = u % N64;
    if (q[0]) r = N64 - r;
    x    = (HALF_PI_Q30 * r) / N64;
    term = x;
    sum  = x;
    term = taylor_mul(term, x) / 64'd6;
    sum  = sum - term;
    term = taylor_mul(term, x) / 64'd20;
    sum  = sum + term;
    term = taylor_mul(term, x) / 64'd42;
    sum  = sum - term;
    term = taylor_mul(term, x) / 64'd72;
    sum  = sum + term;
    term = taylor_mul(term, x) / 64'd110;
    sum  = sum - term;
    term = taylor_mul(term, x) / 64'd156;
    sum  = sum + term;
    if (sum > ONE_Q30) sum = ONE_Q30;
    v = (q >= 64'd2) ? ONE_Q30 - sum : ONE_Q30 + sum;
    return 16'((v * 64'd65535 + ONE_Q30) >> 31);
  endfunction

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_entry
    localparam logic [15:0] ENTRY = sine_entry(g);
    assign tbl[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= tbl[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rgb_led_pattern_animator.sv =====
// rgb led pattern animator
// in channel: one request per accept; in_tuser[0] is the kind (tick or set),
// in_tdata carries the new colour, pattern and speed, used only on a set.
// out channel: one colour per emitted request, red in the low byte.
// cfg port: apb-style register file, writes are registered, reads are
// combinational; the user must write registers only while the block is
// idle, the block itself does not enforce it. a tick that emits nothing
// completes in the accept cycle and in_tready stays high. an emitting
// request walks the sequencer: solid and blink go from S_LEVEL to S_CHAN,
// fade adds S_DIV, pulse adds S_LO, S_HI, S_DIV, S_TBL and S_SCALE, and
// S_OUT raises out_tvalid. QB = max(9, log2 SINE_ENTRIES) is the bit count
// of the shared restoring divider that does the fade ramp and the sine
// table index. channel scaling reuses one 16x8 multiplier for six steps.
// in_tready is high only in the idle state. a finished colour goes to the
// output register; if that register still holds an untaken colour, the
// sequencer waits until out_tready frees it, so no result is dropped.
// after reset the registers take their defaults, the pattern is inactive
// and ticks emit nothing until the first set request.
`include "rgb_led_pattern_animator_assert.svh"

module rgb_led_pattern_animator
  import rgb_anim_pkg::*;
#(
  parameter int SINE_ENTRIES = 256,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // new_color[23:0], new_pattern[26:24], new_speed[28:27]
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB = $clog2(SINE_ENTRIES);
  localparam int QB = (SB > 9) ? SB : 9;
  localparam int DW = 16 + QB;
  localparam int MW = (TIME_BITS > 16) ? TIME_BITS : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_LO, S_HI, S_DIV, S_TBL, S_SCALE, S_CHAN, S_OUT
  } state_t;

  cfg_regs_t cfg;

  state_t               state_r;
  logic                 active_r;
  logic [23:0]          color_r;
  logic [2:0]           pattern_r;
  logic [1:0]           speed_r;
  logic [TIME_BITS-1:0] phase_r;
  logic [TIME_BITS-1:0] since_r;
  logic [7:0]           level_r;
  logic [7:0]           lo_r;
  logic [7:0]           hi_r;
  logic [2:0]           step_r;
  logic [7:0]           chan_r [3];
  logic [23:0]          out_data_r;
  logic                 out_valid_r;

  logic                 in_acc;
  logic                 in_kind;
  logic [15:0]          per_raw;
  logic [15:0]          period;
  logic [TIME_BITS-1:0] since_inc;
  logic [TIME_BITS-1:0] phase_inc;
  logic                 phase_wrap;
  logic                 interval_hit;
  logic [MW-1:0]        phase_ext;
  logic [15:0]          pos;
  logic                 first_half;
  logic [15:0]          ramp_num;
  logic [DW-1:0]        fade_dvd;
  logic [DW-1:0]        pulse_dvd;
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic                 div_done;
  logic [QB-1:0]        div_quo;
  logic [15:0]          sine_val;
  logic [6:0]           pct_in;
  logic [7:0]           pct_lvl;
  logic [7:0]           span;
  logic [1:0]           ch;
  logic                 second;
  logic [7:0]           color_byte;
  logic [15:0]          mul_a;
  logic [7:0]           mul_b;
  logic [23:0]          mul_p;
  logic [7:0]           chan_q;
  logic [7:0]           scale_q;

  rgb_anim_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rgb_anim_div #(.QB(QB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  rgb_anim_sine #(.SINE_ENTRIES(SINE_ENTRIES), .SB(SB)) u_sine (
    .clk     (clk),
    .rd_idx  (div_quo[SB-1:0]),
    .rd_data (sine_val)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_kind    = in_tuser[0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    unique case (speed_r)
      SPEED_SLOW: per_raw = cfg.per_slow;
      SPEED_FAST: per_raw = cfg.per_fast;
      default:    per_raw = cfg.per_normal;
    endcase
  end

  // a zero period acts as one
  assign period = (per_raw == 16'd0) ? 16'd1 : per_raw;

  // tick bookkeeping
  assign since_inc    = (&since_r) ? since_r : since_r + 1'b1;
  assign phase_inc    = phase_r + 1'b1;
  assign phase_wrap   = MW'(phase_inc) >= MW'(period);
  assign interval_hit = MW'(since_inc) >= MW'(cfg.update_interval);

  // phase is below the period whenever a level is computed
  assign phase_ext  = MW'(phase_r);
  assign pos        = phase_ext[15:0];
  assign first_half = {pos, 1'b0} < {1'b0, period};
  assign ramp_num   = first_half ? pos : period - pos;
  assign fade_dvd   = (DW'(ramp_num) << 9) - (DW'(ramp_num) << 1);
  assign pulse_dvd  = DW'(pos) * DW'(SINE_ENTRIES);

  assign div_start    = ((state_r == S_LEVEL) && (pattern_r == PAT_FADE)) ||
                        (state_r == S_HI);
  assign div_dividend = (state_r == S_HI) ? pulse_dvd : fade_dvd;

  assign pct_in  = (state_r == S_LO) ? cfg.pulse_min : cfg.pulse_max;
  assign pct_lvl = pct_to_level(pct_in);
  assign span    = (hi_r >= lo_r) ? hi_r - lo_r : lo_r - hi_r;

  assign ch     = step_r[2:1];
  assign second = step_r[0];

  always_comb begin
    unique case (ch)
      2'd0:    color_byte = color_r[23:16];
      2'd1:    color_byte = color_r[15:8];
      default: color_byte = color_r[7:0];
    endcase
  end

  // shared multiplier: pulse span scaling, then two passes per channel
  always_comb begin
    if (state_r == S_SCALE) begin
      mul_a = sine_val;
      mul_b = span;
    end else begin
      mul_a = {8'd0, second ? chan_r[ch] : color_byte};
      mul_b = second ? cfg.brightness : level_r;
    end
  end

  assign mul_p   = 24'(mul_a) * 24'(mul_b);
  assign chan_q  = div255(mul_p[15:0]);
  assign scale_q = div65535(mul_p);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      color_r     <= '0;
      pattern_r   <= PAT_SOLID;
      speed_r     <= SPEED_NORMAL;
      phase_r     <= '0;
      since_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the output state handles the register itself
      if (out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_SET) begin
              color_r   <= in_tdata[23:0];
              pattern_r <= in_tdata[26:24];
              speed_r   <= in_tdata[28:27];
              active_r  <= 1'b1;
              phase_r   <= '0;
              since_r   <= '0;
              state_r   <= S_LEVEL;
            end else begin
              since_r <= interval_hit ? '0 : since_inc;
              phase_r <= phase_wrap ? '0 : phase_inc;
              if (interval_hit && active_r) state_r <= S_LEVEL;
            end
          end
        end
        S_LEVEL: begin
          step_r <= 3'd0;
          unique case (pattern_r)
            PAT_BLINK, PAT_BLINK_FAST: begin
              level_r <= first_half ? LEVEL_FULL : 8'd0;
              state_r <= S_CHAN;
            end
            PAT_FADE:  state_r <= S_DIV;
            PAT_PULSE: state_r <= S_LO;
            default: begin
              level_r <= LEVEL_FULL;
              state_r <= S_CHAN;
            end
          endcase
        end
        S_LO: begin
          lo_r    <= pct_lvl;
          state_r <= S_HI;
        end
        S_HI: begin
          hi_r    <= pct_lvl;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (pattern_r == PAT_FADE) begin
              level_r <= div_quo[7:0];
              step_r  <= 3'd0;
              state_r <= S_CHAN;
            end else begin
              state_r <= S_TBL;
            end
          end
        end
        S_TBL: state_r <= S_SCALE;
        S_SCALE: begin
          // max below min makes the level fall from min
          level_r <= (hi_r >= lo_r) ? lo_r + scale_q : lo_r - scale_q;
          step_r  <= 3'd0;
          state_r <= S_CHAN;
        end
        S_CHAN: begin
          chan_r[ch] <= chan_q;
          if (step_r == 3'd5) state_r <= S_OUT;
          else step_r <= step_r + 3'd1;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {chan_r[2], chan_r[1], chan_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  `RLPA_IMPLIES(a_div_done_in_wait, div_done, state_r == S_DIV,
    "divider finished outside its wait state")
  `RLPA_NEXT(a_set_starts_level, in_acc && (in_kind == KIND_SET), state_r == S_LEVEL,
    "set request did not start a level computation")
  `RLPA_IMPLIES(a_step_range, state_r == S_CHAN, step_r <= 3'd5,
    "channel step counter out of range")
  `RLPA_NEXT(a_out_no_overwrite, (state_r == S_OUT) && out_valid_r && !out_tready,
    (state_r == S_OUT) && out_valid_r,
    "pending colour overwritten before it was taken")

endmodule

// ===== tb/sv/rgb_led_pattern_animator_tb.sv =====
module rgb_led_pattern_animator_tb;
  import rgb_anim_pkg::*;

  localparam int SINE_N = 256;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_REQS = 72;

  typedef struct packed {
    logic        kind;
    logic [23:0] color;
    logic [2:0]  pattern;
    logic [1:0]  speed;
  } anim_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rgb_led_pattern_animator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block: registers, held pattern and timers
  cfg_regs_t   shadow;
  logic        anim_on;
  logic [23:0] hold_color;
  logic [2:0]  hold_pat;
  logic [1:0]  hold_speed;
  logic [15:0] phase_pos;
  logic [15:0] since_out;
  logic [15:0] sine_tab [SINE_N];

  anim_req_t   pending [$];
  logic [23:0] colors_due [$];
  anim_req_t   cur_req;
  logic [23:0] due_color;
  bit          req_taken = 1'b0;
  bit          color_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned in_idle_max = 11;
  int unsigned out_idle_max = 11;
  int unsigned mismatches = 0;

  task automatic log_mismatch(input string what, input logic [23:0] got,
                              input logic [23:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // (1+sin)/2 in q0.16, quarter wave folded, taylor series in q30
  function automatic logic [15:0] sine_q16(input int unsigned i);
    longint unsigned u, q, r, x, term, acc, v;
    u = 4 * i;
    q = u / SINE_N;
    r = u % SINE_N;
    if (q[0]) r = SINE_N - r;
    x = HALF_PI_Q30 * r / SINE_N;
    term = x;
    acc = x;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc > ONE_Q30) acc = ONE_Q30;
    v = (q >= 2) ? ONE_Q30 - acc : ONE_Q30 + acc;
    return 16'((v * 65535 + ONE_Q30) >> 31);
  endfunction

  function automatic int unsigned period_now();
    logic [15:0] p;
    case (hold_speed)
      SPEED_SLOW: p = shadow.per_slow;
      SPEED_FAST: p = shadow.per_fast;
      default:    p = shadow.per_normal;
    endcase
    return (p == 0) ? 1 : p;
  endfunction

  function automatic int unsigned percent_to_level(input logic [6:0] pct);
    int unsigned c;
    c = (pct > PCT_FULL) ? PCT_FULL : pct;
    return c * 255 / 100;
  endfunction

  function automatic int unsigned anim_level();
    longint unsigned per, pos, t, lo, hi;
    per = period_now();
    pos = phase_pos % per;
    case (hold_pat)
      PAT_BLINK, PAT_BLINK_FAST: return (2 * pos < per) ? 255 : 0;
      PAT_FADE: begin
        if (2 * pos < per) return 510 * pos / per;
        return 510 * (per - pos) / per;
      end
      PAT_PULSE: begin
        t = sine_tab[(pos * SINE_N / per) % SINE_N];
        lo = percent_to_level(shadow.pulse_min);
        hi = percent_to_level(shadow.pulse_max);
        if (hi >= lo) return lo + t * (hi - lo) / 65535;
        return lo - t * (lo - hi) / 65535;
      end
      default: return 255;
    endcase
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] x, input int unsigned lvl);
    int unsigned y;
    y = x * lvl / 255;
    y = y * shadow.brightness / 255;
    return 8'(y);
  endfunction

  // red lands in the low byte of the result
  function automatic logic [23:0] current_color();
    int unsigned lvl;
    lvl = anim_level();
    return {scale_chan(hold_color[7:0], lvl), scale_chan(hold_color[15:8], lvl),
            scale_chan(hold_color[23:16], lvl)};
  endfunction

  task automatic animate_step(input anim_req_t rq);
    if (rq.kind == KIND_SET) begin
      hold_color = rq.color;
      hold_pat = rq.pattern;
      hold_speed = rq.speed;
      anim_on = 1'b1;
      phase_pos = '0;
      since_out = '0;
      colors_due.push_back(current_color());
    end else begin
      if (since_out != 16'hFFFF) since_out = since_out + 16'd1;
      phase_pos = phase_pos + 16'd1;
      if (phase_pos >= period_now()) phase_pos = '0;
      if (since_out >= shadow.update_interval) begin
        since_out = '0;
        if (anim_on) colors_due.push_back(current_color());
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !req_taken)) begin
      if (req_taken) begin
        req_taken = 1'b0;
        in_gap = $urandom_range(0, in_idle_max);
      end
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        cur_req = pending.pop_front();
        in_tdata <= {3'b000, cur_req.speed, cur_req.pattern, cur_req.color};
        in_tuser <= cur_req.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin
    if (color_taken) begin
      color_taken = 1'b0;
      out_hold = $urandom_range(0, out_idle_max);
    end
    if (out_hold != 0) begin
      out_tready <= 1'b0;
      if (out_tvalid) out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted colors
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        req_taken = 1'b1;
        animate_step(cur_req);
      end
      if (out_tvalid && out_tready) begin
        color_taken = 1'b1;
        if (colors_due.size() == 0) begin
          log_mismatch("color with none due", out_tdata, 24'h0);
        end else begin
          due_color = colors_due.pop_front();
          if (out_tdata[7:0] != due_color[7:0])
            log_mismatch("red", out_tdata, due_color);
          if (out_tdata[15:8] != due_color[15:8])
            log_mismatch("green", out_tdata, due_color);
          if (out_tdata[23:16] != due_color[23:16])
            log_mismatch("blue", out_tdata, due_color);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: shadow.brightness = 8'(val);
      REG_PER_SLOW:   shadow.per_slow = 16'(val);
      REG_PER_NORMAL: shadow.per_normal = 16'(val);
      REG_PER_FAST:   shadow.per_fast = 16'(val);
      REG_PULSE_MIN:  shadow.pulse_min = 7'(val);
      REG_PULSE_MAX:  shadow.pulse_max = 7'(val);
      REG_INTERVAL:   shadow.update_interval = 16'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned bright, input int unsigned ps,
                          input int unsigned pn, input int unsigned pf,
                          input int unsigned pmin, input int unsigned pmax,
                          input int unsigned ivl);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_PER_SLOW, ps);
    write_reg(REG_PER_NORMAL, pn);
    write_reg(REG_PER_FAST, pf);
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_PULSE_MAX, pmax);
    write_reg(REG_INTERVAL, ivl);
  endtask

  // wait until every request is in and every color is out
  task automatic settle();
    while (pending.size() != 0 || in_tvalid || colors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic anim_req_t make_req(input logic kind, input logic [23:0] color,
                                         input logic [2:0] pattern, input logic [1:0] speed);
    anim_req_t r;
    r.kind = kind;
    r.color = color;
    r.pattern = pattern;
    r.speed = speed;
    return r;
  endfunction

  function automatic anim_req_t rand_req(input logic kind);
    logic [23:0] c;
    case ($urandom_range(0, 7))
      0: c = 24'h000000;
      1: c = 24'hFFFFFF;
      default: c = 24'($urandom);
    endcase
    return make_req(kind, c, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
  endfunction

  function automatic int unsigned rand_period();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 2);
      default: return $urandom_range(3, 300);
    endcase
  endfunction

  initial begin
    int unsigned n;
    shadow.brightness = RST_BRIGHTNESS;
    shadow.per_slow = RST_PER_SLOW;
    shadow.per_normal = RST_PER_NORMAL;
    shadow.per_fast = RST_PER_FAST;
    shadow.pulse_min = RST_PULSE_MIN;
    shadow.pulse_max = RST_PULSE_MAX;
    shadow.update_interval = RST_INTERVAL;
    anim_on = 1'b0;
    hold_color = '0;
    hold_pat = PAT_SOLID;
    hold_speed = SPEED_NORMAL;
    phase_pos = '0;
    since_out = '0;
    for (int i = 0; i < SINE_N; i++) sine_tab[i] = sine_q16(i);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ticks while inactive, then every pattern and speed
    write_reg(REG_INTERVAL, 1);
    repeat (3) pending.push_back(rand_req(KIND_TICK));
    for (int p = 0; p < 8; p++)
      pending.push_back(make_req(KIND_SET, (p % 2 == 0) ? 24'hFFFFFF : 24'($urandom),
                                 3'(p), 2'(p)));
    settle();
    // pulse with max below min and min above hundred
    write_reg(REG_PULSE_MIN, 127);
    write_reg(REG_PULSE_MAX, 0);
    write_reg(REG_PER_FAST, 7);
    pending.push_back(make_req(KIND_SET, 24'hFFFFFF, PAT_PULSE, SPEED_FAST));
    repeat (6) pending.push_back(rand_req(KIND_TICK));
    pending.push_back(make_req(KIND_SET, 24'hFF00FF, PAT_FADE, SPEED_FAST));
    repeat (5) pending.push_back(rand_req(KIND_TICK));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(255, 0, 1, 2, 0, 100, 0);
        1: set_regs(0, 65535, 65535, 65535, 127, 0, 1);
        2: set_regs(128, $urandom_range(3, 40), $urandom_range(3, 40), $urandom_range(3, 40),
                    $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3));
        3: set_regs($urandom_range(0, 255), rand_period(), rand_period(), rand_period(),
                    $urandom_range(0, 127), $urandom_range(0, 127), 65535);
        default: set_regs($urandom_range(0, 255), rand_period(), rand_period(), rand_period(),
                          $urandom_range(0, 127), $urandom_range(0, 127),
                          ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 5));
      endcase
      in_idle_max = (ph == 5 || ph == 7) ? 0 : 11;
      out_idle_max = (ph == 6 || ph == 7) ? 0 : 11;
      // a set followed by a run of ticks, with a few stray ticks ahead of it
      n = 0;
      while (n < PHASE_REQS) begin
        if ($urandom_range(0, 9) == 0) begin
          pending.push_back(rand_req(KIND_TICK));
          n++;
        end
        pending.push_back(rand_req(KIND_SET));
        n++;
        repeat ($urandom_range(0, 15)) begin
          pending.push_back(rand_req(KIND_TICK));
          n++;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
